@@ design/lru_with_shift_distance_tracker_defines.svh @@
// Assertion macros for the LRU tracker.
`ifndef LRU_WITH_SHIFT_DISTANCE_TRACKER_DEFINES_SVH
`define LRU_WITH_SHIFT_DISTANCE_TRACKER_DEFINES_SVH
`ifndef SYNTH
`define LSWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LSWD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LSWD_ASSERT(lbl, prop, msg)
`define LSWD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ design/lswd_pkg.sv @@
`timescale 1ns / 1ps
package lswd_pkg;

  localparam int SETS_DEF       = 1024;
  localparam int WAYS_DEF       = 16;
  localparam int WINDOW_MAX_DEF = 8;
  localparam int STAMP_W        = 64;
  localparam int WAY_IDX_W      = 4;
  localparam int SET_IDX_W      = 10;
  localparam int CFG_W          = 4;
  localparam int CFG_IDX_W      = 1;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET  = 4'd8;
  localparam logic [CFG_W-1:0] MODE_THRESHOLD_RESET = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_THRESHOLD = 1'd1;

  typedef enum logic [1:0] {
    ACT_QUERY  = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } back_state_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic                 was_hit;
    logic                 is_write;
  } in_beat_t;

  typedef struct packed {
    logic [WAY_IDX_W-1:0] victim_way;
    logic [WAY_IDX_W-1:0] shift_distance;
    logic                 mode_found;
  } out_beat_t;

  typedef struct packed {
    action_t              action;
    logic [SET_IDX_W-1:0] set;
    logic [WAY_IDX_W-1:0] way;
    logic                 stamp;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

@@ design/lru_with_shift_distance_tracker.sv @@
`timescale 1ns / 1ps
// Path: a beat enters the two-entry queue and is popped in IDLE with a row read; a fill or update
// then compares and writes back in EXEC, with the result registered. A new command is taken only in IDLE
// and with the result slot free; a victim query holds the stamp row in SCAN while one compare walks the ways.
// Reset: synchronous, active high; config returns to window 8, threshold 3, counter to zero,
// then a clear pass zeroes both row stores while input is stalled.
module lru_with_shift_distance_tracker #(
  parameter int SETS       = lswd_pkg::SETS_DEF,
  parameter int WAYS       = lswd_pkg::WAYS_DEF,
  parameter int WINDOW_MAX = lswd_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lswd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lswd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lswd_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lswd_pkg::out_beat_t           out_data
);

  logic [lswd_pkg::CFG_W-1:0] window_length;
  logic [lswd_pkg::CFG_W-1:0] mode_threshold;
  lswd_pkg::queue_head_t      head;
  logic                       pop;
  logic                       clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= lswd_pkg::WINDOW_LENGTH_RESET;
      mode_threshold <= lswd_pkg::MODE_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lswd_pkg::REG_WINDOW_LENGTH:  window_length  <= cfg_data;
        lswd_pkg::REG_MODE_THRESHOLD: mode_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  lswd_front #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .pop      (pop),
    .head     (head)
  );

  lswd_back #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .window_length  (window_length),
    .mode_threshold (mode_threshold),
    .head           (head),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

@@ design/lswd_front.sv @@
`timescale 1ns / 1ps
module lswd_front #(
  parameter int SETS = lswd_pkg::SETS_DEF,
  parameter int WAYS = lswd_pkg::WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lswd_pkg::in_beat_t    in_data,
  input  logic                  clearing,
  input  logic                  pop,
  output lswd_pkg::queue_head_t head
);

  lswd_pkg::cmd_t q [lswd_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           push;
  logic           way_ok;
  lswd_pkg::cmd_t cmd_in;
  logic [lswd_pkg::SET_IDX_W-1:0] set_red;

  assign in_stall = (count == 2'd2) || clearing;
  assign push     = in_valid && !in_stall;
  assign way_ok   = 32'(in_data.way_index) < WAYS;

  always_comb begin
    set_red = in_data.set_index;
    for (int k = lswd_pkg::SET_IDX_W - 1; k >= 0; k--) begin
      if (32'(set_red) >= (SETS << k)) begin
        set_red = set_red - lswd_pkg::SET_IDX_W'(SETS << k);
      end
    end
  end

  always_comb begin
    cmd_in.action = lswd_pkg::action_t'(in_data.action);
    cmd_in.set    = set_red;
    cmd_in.way    = in_data.way_index;
    case (lswd_pkg::action_t'(in_data.action))
      lswd_pkg::ACT_FILL:   cmd_in.stamp = way_ok;
      lswd_pkg::ACT_UPDATE: cmd_in.stamp = way_ok && in_data.was_hit && !in_data.is_write;
      default:              cmd_in.stamp = 1'b0;
    endcase
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  assign head.valid = count != 2'd0;
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

@@ design/lswd_back.sv @@
`timescale 1ns / 1ps
`include "lru_with_shift_distance_tracker_defines.svh"
module lswd_back #(
  parameter int SETS       = lswd_pkg::SETS_DEF,
  parameter int WAYS       = lswd_pkg::WAYS_DEF,
  parameter int WINDOW_MAX = lswd_pkg::WINDOW_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lswd_pkg::CFG_W-1:0]  window_length,
  input  logic [lswd_pkg::CFG_W-1:0]  mode_threshold,
  input  lswd_pkg::queue_head_t       head,
  output logic                        pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lswd_pkg::out_beat_t         out_data
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SW     = lswd_pkg::STAMP_W;
  localparam int EW     = lswd_pkg::WAY_IDX_W;
  localparam int ROW_W  = WAYS * SW;
  localparam int WROW_W = WINDOW_MAX * EW;

  logic [ROW_W-1:0]  stamp_mem [SETS];
  logic [WROW_W-1:0] win_mem   [SETS];
  logic [ROW_W-1:0]  stamp_rd;
  logic [WROW_W-1:0] win_rd;

  lswd_pkg::back_state_t state;
  lswd_pkg::back_state_t state_next;
  lswd_pkg::cmd_t        cmd;
  lswd_pkg::cmd_t        cmd_next;
  logic [SET_W-1:0]      clr_addr;
  logic [SET_W-1:0]      clr_addr_next;
  logic [SW-1:0]         stamp_counter;
  logic [SW-1:0]         stamp_counter_next;
  logic [WAY_W-1:0]      best_way;
  logic [WAY_W-1:0]      best_way_next;
  logic [SW-1:0]         best_val;
  logic [SW-1:0]         best_val_next;
  logic [WAY_W-1:0]      scan_idx;
  logic [WAY_W-1:0]      scan_idx_next;
  logic                  out_valid_next;
  lswd_pkg::out_beat_t   out_data_next;

  logic              rd_en;
  logic [SET_W-1:0]  rd_addr;
  logic              stamp_we;
  logic              win_we;
  logic [SET_W-1:0]  wr_addr;
  logic [ROW_W-1:0]  stamp_wd;
  logic [WROW_W-1:0] win_wd;
  logic              out_free;

  logic [SW-1:0]     slot [WAYS];
  logic [WAY_W-1:0]  way_sel;
  logic [ROW_W-1:0]  stamp_row_upd;
  logic              scan_better;

  logic [EW-1:0]     ent [WINDOW_MAX + 1];
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  cnt;
  logic              have;
  logic [EW-1:0]     mode;
  logic [EW-1:0]     prev;
  logic [EW-1:0]     ref_way;
  logic [EW-1:0]     way_gap;
  logic [WROW_W-1:0] win_row_upd;

  assign clearing = state == lswd_pkg::ST_CLEAR;
  assign out_free = !out_valid || !out_stall;
  assign way_sel  = WAY_W'(cmd.way);
  assign rd_addr  = SET_W'(head.cmd.set);

  always_comb begin
    for (int u = 0; u < WAYS; u++) begin
      slot[u] = stamp_rd[u*SW +: SW];
      stamp_row_upd[u*SW +: SW] = (WAY_W'(u) == way_sel) ? stamp_counter : slot[u];
    end
  end

  assign scan_better = slot[scan_idx] < best_val;

  always_comb begin
    for (int u = 0; u < WINDOW_MAX; u++) begin
      ent[u] = win_rd[u*EW +: EW];
    end
    ent[WINDOW_MAX] = '0;
  end

  always_comb begin
    if (window_length < 4'd2) begin
      len = LEN_W'(2);
    end else if (32'(window_length) > WINDOW_MAX) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(window_length);
    end
  end

  always_comb begin
    have = 1'b0;
    mode = '0;
    cnt  = '0;
    for (int u = 0; u < WINDOW_MAX; u++) begin
      cnt = '0;
      for (int j = 0; j <= u; j++) begin
        if (ent[j] == ent[u]) begin
          cnt = cnt + LEN_W'(1);
        end
      end
      if ((u < 32'(len)) && (32'(cnt) >= 32'(mode_threshold))) begin
        have = 1'b1;
        mode = ent[u];
      end
    end
  end

  always_comb begin
    for (int u = 0; u < WINDOW_MAX; u++) begin
      if (u + 1 < 32'(len)) begin
        win_row_upd[u*EW +: EW] = ent[u + 1];
      end else if (u + 1 == 32'(len)) begin
        win_row_upd[u*EW +: EW] = cmd.way;
      end else begin
        win_row_upd[u*EW +: EW] = ent[u];
      end
    end
  end

  assign prev    = ent[len - LEN_W'(1)];
  assign ref_way = have ? mode : prev;
  assign way_gap = (cmd.way >= ref_way) ? (cmd.way - ref_way) : (ref_way - cmd.way);

  always_comb begin
    state_next         = state;
    cmd_next           = cmd;
    clr_addr_next      = clr_addr;
    stamp_counter_next = stamp_counter;
    best_way_next      = best_way;
    best_val_next      = best_val;
    scan_idx_next      = scan_idx;
    out_data_next      = out_data;
    out_valid_next     = out_valid && out_stall;
    pop                = 1'b0;
    rd_en              = 1'b0;
    stamp_we           = 1'b0;
    win_we             = 1'b0;
    wr_addr            = SET_W'(cmd.set);
    stamp_wd           = stamp_row_upd;
    win_wd             = win_row_upd;
    case (state)
      lswd_pkg::ST_CLEAR: begin
        stamp_we = 1'b1;
        win_we   = 1'b1;
        wr_addr  = clr_addr;
        stamp_wd = '0;
        win_wd   = '0;
        if (32'(clr_addr) == SETS - 1) begin
          state_next = lswd_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + SET_W'(1);
        end
      end
      lswd_pkg::ST_IDLE: begin
        if (head.valid && out_free) begin
          pop        = 1'b1;
          rd_en      = 1'b1;
          cmd_next   = head.cmd;
          state_next = lswd_pkg::ST_EXEC;
        end
      end
      lswd_pkg::ST_EXEC: begin
        state_next = lswd_pkg::ST_IDLE;
        out_data_next = '0;
        case (cmd.action)
          lswd_pkg::ACT_QUERY: begin
            best_way_next = '0;
            best_val_next = slot[0];
            scan_idx_next = WAY_W'(1);
            state_next    = lswd_pkg::ST_SCAN;
          end
          lswd_pkg::ACT_FILL: begin
            out_valid_next = 1'b1;
            if (cmd.stamp) begin
              stamp_we           = 1'b1;
              stamp_counter_next = stamp_counter + SW'(1);
            end
          end
          lswd_pkg::ACT_UPDATE: begin
            out_valid_next               = 1'b1;
            win_we                       = 1'b1;
            out_data_next.shift_distance = way_gap;
            out_data_next.mode_found     = have;
            if (cmd.stamp) begin
              stamp_we           = 1'b1;
              stamp_counter_next = stamp_counter + SW'(1);
            end
          end
          default: begin
            out_valid_next = 1'b1;
          end
        endcase
      end
      lswd_pkg::ST_SCAN: begin
        if (scan_better) begin
          best_way_next = scan_idx;
          best_val_next = slot[scan_idx];
        end
        if (32'(scan_idx) == WAYS - 1) begin
          out_valid_next           = 1'b1;
          out_data_next            = '0;
          out_data_next.victim_way = EW'(best_way_next);
          state_next               = lswd_pkg::ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + WAY_W'(1);
        end
      end
      default: begin
        state_next = lswd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lswd_pkg::ST_CLEAR;
      clr_addr      <= '0;
      stamp_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      stamp_counter <= stamp_counter_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    best_way <= best_way_next;
    best_val <= best_val_next;
    scan_idx <= scan_idx_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[wr_addr] <= stamp_wd;
    end
    if (win_we) begin
      win_mem[wr_addr] <= win_wd;
    end
    if (rd_en) begin
      stamp_rd <= stamp_mem[rd_addr];
      win_rd   <= win_mem[rd_addr];
    end
  end

  `LSWD_ASSERT(a_exec_out_empty, (state == lswd_pkg::ST_EXEC) |-> !out_valid, "result slot busy at execute")
  `LSWD_ASSERT(a_no_pop_clear, clearing |-> !pop, "queue popped during clear pass")
  `LSWD_ASSERT(a_scan_idx_nonzero, (state == lswd_pkg::ST_SCAN) |-> (scan_idx != '0), "scan index wrapped")
  `LSWD_ASSERT_NEXT(a_counter_hold, !(stamp_we && (state == lswd_pkg::ST_EXEC)), $stable(stamp_counter), "stamp counter moved without a stamp")

endmodule

@@ tb/lswd_checker.sv @@
`timescale 1ns / 1ps
module lswd_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  lswd_pkg::in_beat_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  lswd_pkg::out_beat_t  out_data,
  output int                   errors,
  output int                   pending
);

  logic [63:0]         stamps [0:lswd_pkg::SETS_DEF*lswd_pkg::WAYS_DEF-1];
  logic [3:0]          window [0:lswd_pkg::SETS_DEF*lswd_pkg::WINDOW_MAX_DEF-1];
  logic [63:0]         stamp_ctr;
  logic [3:0]          win_len;
  logic [3:0]          mode_thr;
  lswd_pkg::out_beat_t expected_q[$];

  function automatic int clamp_len();
    int n;
    n = win_len;
    if (n < 2) n = 2;
    if (n > lswd_pkg::WINDOW_MAX_DEF) n = lswd_pkg::WINDOW_MAX_DEF;
    return n;
  endfunction

  task automatic touch_way(input int s, input int w);
    if (w < lswd_pkg::WAYS_DEF) begin
      stamps[s*lswd_pkg::WAYS_DEF + w] = stamp_ctr;
      stamp_ctr = stamp_ctr + 64'd1;
    end
  endtask

  task automatic predict_access(input lswd_pkg::in_beat_t b);
    lswd_pkg::out_beat_t r;
    int s, w, best, len, md, ref_way, base;
    int counts [16];
    bit have;
    r = '0;
    s = b.set_index % lswd_pkg::SETS_DEF;
    w = b.way_index;
    case (lswd_pkg::action_t'(b.action))
      lswd_pkg::ACT_QUERY: begin
        best = 0;
        for (int i = 1; i < lswd_pkg::WAYS_DEF; i++)
          if (stamps[s*lswd_pkg::WAYS_DEF + i] < stamps[s*lswd_pkg::WAYS_DEF + best]) best = i;
        r.victim_way = 4'(best);
      end
      lswd_pkg::ACT_FILL: touch_way(s, w);
      lswd_pkg::ACT_UPDATE: begin
        base = s*lswd_pkg::WINDOW_MAX_DEF;
        len = clamp_len();
        have = 0;
        md = 0;
        for (int i = 0; i < 16; i++) counts[i] = 0;
        for (int i = 0; i < len; i++) begin
          counts[window[base+i]]++;
          if (counts[window[base+i]] >= mode_thr) begin
            have = 1;
            md = window[base+i];
          end
        end
        for (int i = 0; i + 1 < len; i++) window[base+i] = window[base+i+1];
        window[base+len-1] = 4'(w);
        ref_way = have ? md : window[base+len-2];
        r.shift_distance = 4'((w >= ref_way) ? w - ref_way : ref_way - w);
        r.mode_found = have;
        if (b.was_hit && !b.is_write) touch_way(s, w);
      end
      default: ;
    endcase
    expected_q.insert(expected_q.size(), r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (stamps[i]) stamps[i] = '0;
      foreach (window[i]) window[i] = '0;
      stamp_ctr = '0;
      win_len = lswd_pkg::WINDOW_LENGTH_RESET;
      mode_thr = lswd_pkg::MODE_THRESHOLD_RESET;
      expected_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == lswd_pkg::REG_WINDOW_LENGTH) win_len = cfg_data;
        else mode_thr = cfg_data;
      end
      if (in_valid && !in_stall) predict_access(in_data);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, out_data);
          errors++;
        end else begin
          lswd_pkg::out_beat_t e;
          e = expected_q.pop_front();
          if (e.victim_way !== out_data.victim_way) begin
            $display("%0t: victim_way expected %0d actual %0d", $time, e.victim_way,
                     out_data.victim_way);
            errors++;
          end
          if (e.shift_distance !== out_data.shift_distance) begin
            $display("%0t: shift_distance expected %0d actual %0d", $time,
                     e.shift_distance, out_data.shift_distance);
            errors++;
          end
          if (e.mode_found !== out_data.mode_found) begin
            $display("%0t: mode_found expected %0d actual %0d", $time, e.mode_found,
                     out_data.mode_found);
            errors++;
          end
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

@@ tb/tb_lru_with_shift_distance_tracker.sv @@
`timescale 1ns / 1ps
module tb_lru_with_shift_distance_tracker;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [lswd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lswd_pkg::CFG_W-1:0]     cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  lswd_pkg::in_beat_t             in_data;
  logic                           out_valid;
  logic                           out_stall;
  lswd_pkg::out_beat_t            out_data;
  int                             errors;
  int                             pending;
  bit                             calm;

  lru_with_shift_distance_tracker DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  lswd_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index[0]),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
  end

  task automatic send_access(input lswd_pkg::in_beat_t b);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (lswd_pkg::WAYS_DEF + 8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lswd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lswd_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  function automatic lswd_pkg::in_beat_t make_access(input logic [1:0] act, input int s,
                                                     input int w, input bit h, input bit wr);
    lswd_pkg::in_beat_t b;
    b.action = act;
    b.set_index = 10'(s);
    b.way_index = 4'(w);
    b.was_hit = h;
    b.is_write = wr;
    return b;
  endfunction

  function automatic lswd_pkg::in_beat_t random_access(input bit focused);
    lswd_pkg::in_beat_t b;
    int r;
    b = lswd_pkg::in_beat_t'($urandom);
    if (focused) begin
      r = $urandom_range(99);
      b.action = r < 20 ? lswd_pkg::ACT_QUERY : r < 40 ? lswd_pkg::ACT_FILL :
                 r < 97 ? lswd_pkg::ACT_UPDATE : lswd_pkg::ACT_NONE;
      b.set_index = $urandom_range(3) == 0 ? 10'($urandom_range(1023)) :
                                             10'($urandom_range(3));
      b.way_index = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    end
    return b;
  endfunction

  initial begin
    logic [3:0] lens [0:4];
    logic [3:0] thrs [0:4];
    lens = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5};
    thrs = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2};
    rst = 1;
    calm = 0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_access(make_access(lswd_pkg::ACT_QUERY, 0, 0, 0, 0));
    send_access(make_access(lswd_pkg::ACT_FILL, 1023, 15, 0, 0));
    send_access(make_access(lswd_pkg::ACT_FILL, 1023, 0, 1, 1));
    send_access(make_access(lswd_pkg::ACT_QUERY, 1023, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_access(make_access(lswd_pkg::ACT_UPDATE, 5, 7, 1, 0));
    send_access(make_access(lswd_pkg::ACT_UPDATE, 5, 15, 1, 1));
    send_access(make_access(lswd_pkg::ACT_UPDATE, 5, 0, 0, 0));
    send_access(make_access(lswd_pkg::ACT_UPDATE, 6, 3, 0, 1));
    send_access(make_access(lswd_pkg::ACT_NONE, 7, 9, 1, 0));
    send_access(make_access(lswd_pkg::ACT_NONE, 1023, 15, 1, 1));
    send_access(make_access(lswd_pkg::ACT_QUERY, 5, 0, 1, 1));
    send_access(make_access(lswd_pkg::ACT_QUERY, 512, 8, 0, 0));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(lswd_pkg::REG_WINDOW_LENGTH, lens[ph]);
      write_reg(lswd_pkg::REG_MODE_THRESHOLD, thrs[ph]);
      cfg_write <= 1'b0;
      calm = (ph == 2);
      for (int i = 0; i < 90; i++) send_access(random_access($urandom_range(9) != 0));
    end
    calm = 0;
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
